// File: hw/rtl/lfsa_pkg.sv
package lfsa_pkg;

   localparam int DEFAULT_SLOTS = 256;
   // slot numbers are 8 bits wide, so no pool holds more than this
   localparam int MAX_POOL      = 256;
   localparam int INDEX_W       = 8;
   localparam int COUNT_W       = 9;

   typedef enum logic {
      MODE_ALLOC   = 1'b0,
      MODE_RELEASE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_NO_FREE      = 2'd1,
      ST_RANGE        = 2'd2,
      ST_ALREADY_FREE = 2'd3
   } status_type;

   typedef struct packed {
      mode_type             mode;
      logic [INDEX_W-1:0]   slot_index;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [INDEX_W-1:0]   granted_index;
      logic [COUNT_W-1:0]   free_count;
   } rsp_type;

endpackage

// File: hw/rtl/lifo_free_slot_allocator_unit.sv
// Free-slot allocator: hands out and takes back slot numbers from a pool kept
// as a last-in first-out stack of free slots.
// Request channel: drive req_data and raise start; the word is taken at the
// clock edge where start is high and busy is low. mode allocate pops the most
// recently freed slot, mode release pushes slot_index back after checking
// that it lies below the slot count and is currently taken.
// Response channel: rsp_strobe is high for exactly one cycle with rsp_data,
// in the cycle after busy, registered from the update made while busy. The
// receiver cannot stall; every response must be taken in its cycle.
// A new request is not taken until the last one is done: the stack memory's
// registered read is followed by the update/write-back, while busy is high.
// csr_write_enable loads the slot count (capped at the pool size) and rebuilds
// the pool so slots come out as 0, 1, 2 and so on, all free; write it only
// while idle. Reset does the same with the full pool. No clearing pass is
// needed: stack entries below the lowest depth reached since the rebuild are
// generated and slots not yet handed out since then read as free, so the
// block is ready in the cycle after reset.
module lifo_free_slot_allocator_unit #(
   parameter int SLOTS = lfsa_pkg::DEFAULT_SLOTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lfsa_pkg::req_type             req_data,
   output logic                          rsp_strobe,
   output lfsa_pkg::rsp_type             rsp_data,
   input  logic                          csr_write_enable,
   input  logic [lfsa_pkg::COUNT_W-1:0]  csr_write_data
);
   import lfsa_pkg::*;

   localparam int Depth = (SLOTS < MAX_POOL) ? SLOTS : MAX_POOL;
   localparam int AW    = $clog2(Depth);
   localparam int CW    = $clog2(Depth + 1);

   logic          busy_ff, busy_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   req_type       req_ff, req_in;
   rsp_type       rsp_ff, rsp_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] top_ff, top_in;
   logic [CW-1:0] mark_ff, mark_in;

   logic          accept;
   logic [CW-1:0] csr_count;
   logic [CW-1:0] top_m1;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_data;
   logic          ram_wr_en;
   logic          flag_rd_value;
   logic          flag_wr_en;
   logic [AW-1:0] flag_wr_addr;
   logic          flag_wr_value;
   logic [AW-1:0] stack_val;
   logic          pop_ok;
   logic          in_range;
   logic          reached;
   logic          push_ok;
   status_type    status;

   assign accept    = start && !busy_ff;
   assign csr_count = (csr_write_data > COUNT_W'(Depth)) ? CW'(Depth)
                                                         : csr_write_data[CW-1:0];
   assign top_m1    = top_ff - CW'(1);
   assign ram_rd_en = accept;

   // entries below the low-water mark were never popped since the rebuild
   assign stack_val = (top_m1 < mark_ff) ? AW'(count_ff - CW'(1) - top_m1)
                                         : ram_rd_data;

   // slots below count minus mark have been handed out since the rebuild,
   // so only their flags are current; all others are free
   assign reached  = COUNT_W'(req_ff.slot_index) < COUNT_W'(count_ff - mark_ff);

   assign pop_ok   = (req_ff.mode == MODE_ALLOC) && (top_ff != '0);
   assign in_range = COUNT_W'(req_ff.slot_index) < COUNT_W'(count_ff);
   assign push_ok  = (req_ff.mode == MODE_RELEASE) && in_range && reached
                     && flag_rd_value && (top_ff < CW'(Depth));
   assign ram_wr_en = busy_ff && push_ok;

   always_comb begin
      priority if (req_ff.mode == MODE_ALLOC) begin
         status = pop_ok ? ST_OK : ST_NO_FREE;
      end else if (!in_range) begin
         status = ST_RANGE;
      end else if (!push_ok) begin
         status = ST_ALREADY_FREE;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      flag_wr_en    = 1'b0;
      flag_wr_addr  = stack_val;
      flag_wr_value = 1'b1;
      if (busy_ff && pop_ok) begin
         flag_wr_en = 1'b1;
      end else if (busy_ff && push_ok) begin
         flag_wr_en    = 1'b1;
         flag_wr_addr  = req_ff.slot_index[AW-1:0];
         flag_wr_value = 1'b0;
      end
   end

   always_comb begin
      busy_in       = busy_ff;
      rsp_strobe_in = busy_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      mark_in       = mark_ff;
      if (reset) begin
         busy_in       = 1'b0;
         rsp_strobe_in = 1'b0;
         count_in      = CW'(Depth);
         top_in        = CW'(Depth);
         mark_in       = CW'(Depth);
      end else if (csr_write_enable) begin
         count_in = csr_count;
         top_in   = csr_count;
         mark_in  = csr_count;
      end else if (busy_ff) begin
         busy_in = 1'b0;
         if (pop_ok) begin
            top_in = top_m1;
            if (top_m1 < mark_ff) begin
               mark_in = top_m1;
            end
         end else if (push_ok) begin
            top_in = top_ff + CW'(1);
         end
         rsp_in.status        = status;
         rsp_in.granted_index = pop_ok ? INDEX_W'(stack_val) : '0;
         rsp_in.free_count    = COUNT_W'(top_in);
      end else if (accept) begin
         busy_in = 1'b1;
         req_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      busy_ff       <= busy_in;
      rsp_strobe_ff <= rsp_strobe_in;
      count_ff      <= count_in;
      top_ff        <= top_in;
      mark_ff       <= mark_in;
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   lfsa_stack_ram #(
      .DEPTH (Depth),
      .WIDTH (AW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (top_ff[AW-1:0]),
      .wr_data (req_ff.slot_index[AW-1:0]),
      .rd_en   (ram_rd_en),
      .rd_addr (top_m1[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   lfsa_taken_flags #(
      .DEPTH (Depth)
   ) u_taken (
      .clock    (clock),
      .wr_en    (flag_wr_en),
      .wr_addr  (flag_wr_addr),
      .wr_value (flag_wr_value),
      .rd_en    (accept),
      .rd_addr  (req_data.slot_index[AW-1:0]),
      .rd_value (flag_rd_value)
   );

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_top_le_count: assert property (@(posedge clock) disable iff (reset)
      top_ff <= count_ff) else $error("stack top above slot count");

   a_mark_le_top: assert property (@(posedge clock) disable iff (reset)
      mark_ff <= top_ff) else $error("low-water mark above stack top");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff) else $error("busy held longer than one cycle");

   a_rsp_follows_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> rsp_strobe_ff) else $error("missing response strobe");

endmodule

// File: hw/rtl/lfsa_stack_ram.sv
module lfsa_stack_ram #(
   parameter int DEPTH = lfsa_pkg::DEFAULT_SLOTS,
   parameter int WIDTH = lfsa_pkg::INDEX_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import lfsa_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lfsa_taken_flags.sv
module lfsa_taken_flags #(
   parameter int DEPTH = lfsa_pkg::DEFAULT_SLOTS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic                     wr_value,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic                     rd_value
);
   import lfsa_pkg::*;

   logic flags_ff [DEPTH];
   logic rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         flags_ff[wr_addr] <= wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_value_ff <= flags_ff[rd_addr];
      end
   end

   assign rd_value = rd_value_ff;

endmodule
